/* rtl/sexpr_completeness_scanner_core_macros.svh */
// assertion helpers for the scanner core rtl
`ifndef SEXPR_COMPLETENESS_SCANNER_CORE_MACROS_SVH
`define SEXPR_COMPLETENESS_SCANNER_CORE_MACROS_SVH

// clocked check, held off while reset is low
`define SCS_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scs_pkg.sv */
package scs_pkg;

  localparam int OUT_LINE_W = 24;
  localparam int OUT_COL_W  = 16;
  localparam int PREFIX_W   = 8;

  typedef enum logic [3:0] {
    LX_NORMAL     = 4'd0,
    LX_STRING     = 4'd1,
    LX_ESCAPE     = 4'd2,
    LX_COMMENT    = 4'd3,
    LX_HASH       = 4'd4,
    LX_COMMA      = 4'd5,
    LX_CHAR       = 4'd6,
    LX_ATOM       = 4'd7,
    LX_ERR_CLOSE  = 4'd8,
    LX_ERR_PREFIX = 4'd9,
    LX_ERR_DEPTH  = 4'd10
  } lex_state_t;

  typedef enum logic [2:0] {
    ST_COMPLETE     = 3'd0,
    ST_INCOMPLETE   = 3'd1,
    ST_UNEXP_CLOSE  = 3'd2,
    ST_PREFIX_CLOSE = 3'd3,
    ST_NEST_OVF     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    D_HOLD = 2'd0,
    D_INC  = 2'd1,
    D_DEC  = 2'd2
  } depth_op_t;

  typedef enum logic [1:0] {
    P_HOLD = 2'd0,
    P_INC  = 2'd1,
    P_CLR  = 2'd2,
    P_ONE  = 2'd3
  } prefix_op_t;

  // counter summaries fed to the byte decoder
  typedef struct packed {
    logic depth_zero;
    logic depth_full;
    logic prefix_zero;
  } scs_flags_t;

  // decoded action for one beat
  typedef struct packed {
    lex_state_t lex_nxt;
    logic       emit;
    status_t    status;
    depth_op_t  depth_op;
    prefix_op_t prefix_op;
    logic       advance;
    logic       clear;
  } scs_ctrl_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

endpackage

/* rtl/sexpr_completeness_scanner_core.sv */
// Lisp source completeness scanner. Feed the text one byte per beat with
// in_mode low, then one beat with in_mode high to mark the end of text. A
// byte beat returns a result only when it hits an error (stray close paren,
// close paren after a pending reader prefix, or nesting past the depth
// limit), and the scanner then holds that error until the end beat. The
// end beat always returns complete, incomplete or the held error, and
// resets the scanner for the next text. Error results carry the 1-based
// line and column of the offending byte; line and column saturate.
// Throughput is one beat per cycle while in_stall is low, with the lexer state
// and the depth, prefix and position counters all updated together on each
// step; an accepted beat sits in the input register, then its result lands in
// the result register, which drives the output. in_stall rises only
// while a decoded beat cannot move on because an earlier result is still
// held by out_stall.
module sexpr_completeness_scanner_core #(
  parameter int DEPTH_BITS  = 16,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [23:0] out_error_line,
  output logic [15:0] out_error_column
);

  // input register
  logic       pipe_valid_r;
  logic       pipe_mode_r;
  logic [7:0] pipe_byte_r;

  // scanner state
  scs_pkg::lex_state_t            lex_r;
  logic [DEPTH_BITS-1:0]          depth_r;
  logic [scs_pkg::PREFIX_W-1:0]   prefix_r;
  logic [LINE_BITS-1:0]           line_r;
  logic [COLUMN_BITS-1:0]         col_r;

  // result register
  logic                           out_valid_r;
  scs_pkg::status_t               out_status_r;
  logic [scs_pkg::OUT_LINE_W-1:0] out_line_r;
  logic [scs_pkg::OUT_COL_W-1:0]  out_col_r;

  scs_pkg::scs_flags_t flags;
  scs_pkg::scs_ctrl_t  ctrl;
  logic                step_en;
  logic                in_take;
  logic [31:0]         line_ext;
  logic [31:0]         col_ext;

  // the held beat moves on whenever the result slot is free or draining
  assign step_en  = pipe_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = pipe_valid_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  assign flags.depth_zero  = (depth_r == '0);
  assign flags.depth_full  = (&depth_r);
  assign flags.prefix_zero = (prefix_r == '0);

  scs_step u_step (
    .lex_i   (lex_r),
    .mode_i  (pipe_mode_r),
    .byte_i  (pipe_byte_r),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // position goes out as its low bits, zero-filled when the counter is narrow
  assign line_ext = 32'(line_r);
  assign col_ext  = 32'(col_r);

  // input register: loads on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
    end else if (in_take) begin
      pipe_valid_r <= 1'b1;
    end else if (step_en) begin
      pipe_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pipe_mode_r <= in_mode;
      pipe_byte_r <= in_byte_value;
    end
  end

  // scanner state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r    <= scs_pkg::LX_NORMAL;
      depth_r  <= '0;
      prefix_r <= '0;
      line_r   <= LINE_BITS'(1);
      col_r    <= COLUMN_BITS'(1);
    end else if (step_en) begin
      lex_r <= ctrl.lex_nxt;
      if (ctrl.clear) begin
        // end of text: back to the start for the next text
        depth_r  <= '0;
        prefix_r <= '0;
        line_r   <= LINE_BITS'(1);
        col_r    <= COLUMN_BITS'(1);
      end else begin
        unique case (ctrl.depth_op)
          scs_pkg::D_INC: depth_r <= depth_r + DEPTH_BITS'(1);
          scs_pkg::D_DEC: depth_r <= depth_r - DEPTH_BITS'(1);
          default:        depth_r <= depth_r;
        endcase
        unique case (ctrl.prefix_op)
          scs_pkg::P_INC: begin
            // prefix count saturates
            if (!(&prefix_r)) prefix_r <= prefix_r + scs_pkg::PREFIX_W'(1);
          end
          scs_pkg::P_CLR:  prefix_r <= '0;
          scs_pkg::P_ONE:  prefix_r <= scs_pkg::PREFIX_W'(1);
          default:         prefix_r <= prefix_r;
        endcase
        if (ctrl.advance) begin
          if (pipe_byte_r == scs_pkg::CH_NL) begin
            if (!(&line_r)) line_r <= line_r + LINE_BITS'(1);
            col_r <= COLUMN_BITS'(1);
          end else if (!(&col_r)) begin
            col_r <= col_r + COLUMN_BITS'(1);
          end
        end
      end
    end
  end

  // result register: a new result only lands when the slot is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && ctrl.emit) begin
      out_status_r <= ctrl.status;
      if (ctrl.status == scs_pkg::ST_COMPLETE || ctrl.status == scs_pkg::ST_INCOMPLETE) begin
        out_line_r <= '0;
        out_col_r  <= '0;
      end else begin
        out_line_r <= line_ext[scs_pkg::OUT_LINE_W-1:0];
        out_col_r  <= col_ext[scs_pkg::OUT_COL_W-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_error_line   = out_line_r;
  assign out_error_column = out_col_r;

`include "sexpr_completeness_scanner_core_macros.svh"

  // once an error is latched, byte beats leave the scanner untouched
  `SCS_ASSERT_CLK(a_err_frozen,
    (step_en && !pipe_mode_r && (lex_r == scs_pkg::LX_ERR_CLOSE ||
      lex_r == scs_pkg::LX_ERR_PREFIX || lex_r == scs_pkg::LX_ERR_DEPTH)) |=>
    (lex_r == $past(lex_r) && line_r == $past(line_r) && col_r == $past(col_r) &&
      !out_valid_r),
    "byte beat changed a frozen error")

  // the end beat returns the scanner to its start state and posts a result
  `SCS_ASSERT_CLK(a_end_clears,
    (step_en && pipe_mode_r) |=>
    (out_valid_r && lex_r == scs_pkg::LX_NORMAL && depth_r == '0 && prefix_r == '0 &&
      line_r == LINE_BITS'(1) && col_r == COLUMN_BITS'(1)),
    "end beat did not reset the scanner")

  // a held result is never overwritten by the next step
  `SCS_ASSERT_ALWAYS(a_no_overwrite,
    (out_valid_r && out_stall) |-> !step_en,
    "result register overwritten while stalled")

endmodule

/* rtl/scs_step.sv */
module scs_step (
  input  scs_pkg::lex_state_t lex_i,
  input  logic                mode_i,
  input  logic [7:0]          byte_i,
  input  scs_pkg::scs_flags_t flags_i,
  output scs_pkg::scs_ctrl_t  ctrl_o
);

  function automatic logic is_space(input logic [7:0] b);
    return b == scs_pkg::CH_SPACE || b == scs_pkg::CH_TAB || b == scs_pkg::CH_NL ||
           b == scs_pkg::CH_VT || b == scs_pkg::CH_FF || b == scs_pkg::CH_CR;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return b == scs_pkg::CH_NUL || is_space(b) || b == scs_pkg::CH_LPAREN ||
           b == scs_pkg::CH_RPAREN || b == scs_pkg::CH_SEMI || b == scs_pkg::CH_QUOTE ||
           b == scs_pkg::CH_DQUOTE || b == scs_pkg::CH_BQUOTE || b == scs_pkg::CH_COMMA;
  endfunction

  logic delim;
  logic from_hash;
  logic pz_eff;
  logic use_norm;
  logic is_err;
  scs_pkg::lex_state_t lex_nxt;

  assign delim     = is_delim(byte_i);
  assign from_hash = (lex_i == scs_pkg::LX_HASH);
  // a hash that falls through drops its prefixes before the byte is rescanned
  assign pz_eff    = flags_i.prefix_zero || from_hash;
  assign is_err    = (lex_i == scs_pkg::LX_ERR_CLOSE) || (lex_i == scs_pkg::LX_ERR_PREFIX) ||
                     (lex_i == scs_pkg::LX_ERR_DEPTH);
  // bytes that go through the top-level reader dispatch
  assign use_norm  = (lex_i == scs_pkg::LX_NORMAL) ||
                     (from_hash && delim && byte_i != scs_pkg::CH_QUOTE) ||
                     (lex_i == scs_pkg::LX_COMMA && byte_i != scs_pkg::CH_AT) ||
                     (lex_i == scs_pkg::LX_ATOM && delim);

  // next lexer state
  always_comb begin
    lex_nxt = lex_i;
    if (mode_i) begin
      lex_nxt = scs_pkg::LX_NORMAL;
    end else if (use_norm) begin
      priority if (byte_i == scs_pkg::CH_NUL || is_space(byte_i)) begin
        lex_nxt = scs_pkg::LX_NORMAL;
      end else if (byte_i == scs_pkg::CH_SEMI) begin
        lex_nxt = scs_pkg::LX_COMMENT;
      end else if (byte_i == scs_pkg::CH_RPAREN) begin
        if (!pz_eff) begin
          lex_nxt = scs_pkg::LX_ERR_PREFIX;
        end else if (flags_i.depth_zero) begin
          lex_nxt = scs_pkg::LX_ERR_CLOSE;
        end else begin
          lex_nxt = scs_pkg::LX_NORMAL;
        end
      end else if (byte_i == scs_pkg::CH_QUOTE || byte_i == scs_pkg::CH_BQUOTE) begin
        lex_nxt = scs_pkg::LX_NORMAL;
      end else if (byte_i == scs_pkg::CH_COMMA) begin
        lex_nxt = scs_pkg::LX_COMMA;
      end else if (byte_i == scs_pkg::CH_HASH) begin
        lex_nxt = scs_pkg::LX_HASH;
      end else if (byte_i == scs_pkg::CH_LPAREN) begin
        lex_nxt = flags_i.depth_full ? scs_pkg::LX_ERR_DEPTH : scs_pkg::LX_NORMAL;
      end else if (byte_i == scs_pkg::CH_DQUOTE) begin
        lex_nxt = scs_pkg::LX_STRING;
      end else begin
        lex_nxt = scs_pkg::LX_ATOM;
      end
    end else begin
      unique case (lex_i)
        scs_pkg::LX_STRING: begin
          if (byte_i == scs_pkg::CH_BSLASH) begin
            lex_nxt = scs_pkg::LX_ESCAPE;
          end else if (byte_i == scs_pkg::CH_DQUOTE) begin
            lex_nxt = scs_pkg::LX_NORMAL;
          end
        end
        scs_pkg::LX_ESCAPE: lex_nxt = scs_pkg::LX_STRING;
        scs_pkg::LX_COMMENT: begin
          if (byte_i == scs_pkg::CH_NL) lex_nxt = scs_pkg::LX_NORMAL;
        end
        scs_pkg::LX_HASH: begin
          if (byte_i == scs_pkg::CH_QUOTE) begin
            lex_nxt = scs_pkg::LX_NORMAL;
          end else if (byte_i == scs_pkg::CH_BSLASH) begin
            lex_nxt = scs_pkg::LX_CHAR;
          end else begin
            lex_nxt = scs_pkg::LX_ATOM;
          end
        end
        // only comma-at lands here
        scs_pkg::LX_COMMA: lex_nxt = scs_pkg::LX_NORMAL;
        scs_pkg::LX_CHAR: lex_nxt = delim ? scs_pkg::LX_NORMAL : scs_pkg::LX_ATOM;
        default: lex_nxt = lex_i;
      endcase
    end
  end

  // counter actions and result
  always_comb begin
    scs_pkg::prefix_op_t pop_base;
    pop_base           = scs_pkg::P_HOLD;
    ctrl_o.lex_nxt     = lex_nxt;
    ctrl_o.emit        = 1'b0;
    ctrl_o.status      = scs_pkg::ST_COMPLETE;
    ctrl_o.depth_op    = scs_pkg::D_HOLD;
    ctrl_o.prefix_op   = scs_pkg::P_HOLD;
    ctrl_o.advance     = 1'b0;
    ctrl_o.clear       = 1'b0;
    if (mode_i) begin
      ctrl_o.emit  = 1'b1;
      ctrl_o.clear = 1'b1;
      if (lex_i == scs_pkg::LX_ERR_CLOSE) begin
        ctrl_o.status = scs_pkg::ST_UNEXP_CLOSE;
      end else if (lex_i == scs_pkg::LX_ERR_PREFIX) begin
        ctrl_o.status = scs_pkg::ST_PREFIX_CLOSE;
      end else if (lex_i == scs_pkg::LX_ERR_DEPTH) begin
        ctrl_o.status = scs_pkg::ST_NEST_OVF;
      end else if (lex_i == scs_pkg::LX_STRING || lex_i == scs_pkg::LX_ESCAPE ||
                   lex_i == scs_pkg::LX_CHAR || !flags_i.depth_zero ||
                   (!flags_i.prefix_zero && !from_hash)) begin
        ctrl_o.status = scs_pkg::ST_INCOMPLETE;
      end
    end else if (use_norm) begin
      ctrl_o.advance = 1'b1;
      priority if (byte_i == scs_pkg::CH_NUL || is_space(byte_i) ||
                   byte_i == scs_pkg::CH_SEMI || byte_i == scs_pkg::CH_HASH) begin
        pop_base = scs_pkg::P_HOLD;
      end else if (byte_i == scs_pkg::CH_RPAREN) begin
        if (!pz_eff) begin
          ctrl_o.emit    = 1'b1;
          ctrl_o.status  = scs_pkg::ST_PREFIX_CLOSE;
          ctrl_o.advance = 1'b0;
        end else if (flags_i.depth_zero) begin
          ctrl_o.emit    = 1'b1;
          ctrl_o.status  = scs_pkg::ST_UNEXP_CLOSE;
          ctrl_o.advance = 1'b0;
        end else begin
          ctrl_o.depth_op = scs_pkg::D_DEC;
        end
      end else if (byte_i == scs_pkg::CH_QUOTE || byte_i == scs_pkg::CH_BQUOTE ||
                   byte_i == scs_pkg::CH_COMMA) begin
        pop_base = scs_pkg::P_INC;
      end else if (byte_i == scs_pkg::CH_LPAREN) begin
        pop_base = scs_pkg::P_CLR;
        if (flags_i.depth_full) begin
          ctrl_o.emit    = 1'b1;
          ctrl_o.status  = scs_pkg::ST_NEST_OVF;
          ctrl_o.advance = 1'b0;
        end else begin
          ctrl_o.depth_op = scs_pkg::D_INC;
        end
      end else begin
        pop_base = scs_pkg::P_CLR;
      end
      if (from_hash) begin
        unique case (pop_base)
          scs_pkg::P_HOLD: ctrl_o.prefix_op = scs_pkg::P_CLR;
          scs_pkg::P_INC:  ctrl_o.prefix_op = scs_pkg::P_ONE;
          default:         ctrl_o.prefix_op = pop_base;
        endcase
      end else begin
        ctrl_o.prefix_op = pop_base;
      end
    end else if (!is_err) begin
      ctrl_o.advance = 1'b1;
      if (from_hash) begin
        ctrl_o.prefix_op = (byte_i == scs_pkg::CH_QUOTE) ? scs_pkg::P_INC : scs_pkg::P_CLR;
      end
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // run-level limits
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 250;  // per idling phase
  localparam int PREFIX_RUN   = 260;  // enough quotes to pin the prefix count
  localparam int TAIL_CYCLES  = 20;

  // one beat on the text channel
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } text_beat_t;

  // one verdict on the result channel
  typedef struct packed {
    scs_pkg::status_t status;
    logic [23:0]      line;
    logic [15:0]      column;
  } verdict_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_mode       = 1'b0;
  logic [7:0]  in_byte_value = 8'h00;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [23:0] out_error_line;
  logic [15:0] out_error_column;

  sexpr_completeness_scanner_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_error_line   (out_error_line),
    .out_error_column (out_error_column)
  );

  // text still to be sent, and verdicts still owed by the block
  text_beat_t text_q[$];
  verdict_t   verdict_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  bit in_took       = 1'b0;
  bit failed        = 1'b0;

  int n_queued       = 0;
  int n_beats        = 0;
  int n_results      = 0;
  int n_backpressure = 0;
  int n_cycles       = 0;
  int n_by_status [0:7];

  // shadow copy of the scanner state
  scs_pkg::lex_state_t sc_lex    = scs_pkg::LX_NORMAL;
  logic [15:0]         sc_depth  = '0;
  logic [7:0]          sc_prefix = '0;
  logic [23:0]         sc_line   = 24'd1;
  logic [15:0]         sc_col    = 16'd1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scanner predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_white(logic [7:0] b);
    return b == scs_pkg::CH_SPACE || b == scs_pkg::CH_TAB || b == scs_pkg::CH_NL ||
           b == scs_pkg::CH_VT || b == scs_pkg::CH_FF || b == scs_pkg::CH_CR;
  endfunction

  // bytes that end an atom or follow a lone hash as plain text
  function automatic bit is_delim(logic [7:0] b);
    return b == scs_pkg::CH_NUL || is_white(b) || b == scs_pkg::CH_LPAREN ||
           b == scs_pkg::CH_RPAREN || b == scs_pkg::CH_SEMI || b == scs_pkg::CH_QUOTE ||
           b == scs_pkg::CH_DQUOTE || b == scs_pkg::CH_BQUOTE || b == scs_pkg::CH_COMMA;
  endfunction

  // line and column of the next byte, both saturating
  function automatic void step_position(logic [7:0] b);
    if (b == scs_pkg::CH_NL) begin
      if (sc_line != '1) sc_line = sc_line + 24'd1;
      sc_col = 16'd1;
    end else if (sc_col != '1) begin
      sc_col = sc_col + 16'd1;
    end
  endfunction

  function automatic void bump_prefix();
    if (sc_prefix != '1) sc_prefix = sc_prefix + 8'd1;
  endfunction

  // lock the scanner in an error state; position stays on the bad byte
  function automatic scs_pkg::status_t freeze(scs_pkg::lex_state_t err_lex,
                                              scs_pkg::status_t code);
    sc_lex = err_lex;
    return code;
  endfunction

  function automatic scs_pkg::status_t open_list();
    sc_prefix = '0;
    if (sc_depth == '1) return freeze(scs_pkg::LX_ERR_DEPTH, scs_pkg::ST_NEST_OVF);
    sc_depth = sc_depth + 16'd1;
    sc_lex   = scs_pkg::LX_NORMAL;
    step_position(scs_pkg::CH_LPAREN);
    return scs_pkg::ST_COMPLETE;
  endfunction

  // byte seen between tokens; ST_COMPLETE here just means no error
  function automatic scs_pkg::status_t top_level_byte(logic [7:0] b);
    sc_lex = scs_pkg::LX_NORMAL;
    if (b == scs_pkg::CH_NUL || is_white(b)) begin
      // skipped
    end else if (b == scs_pkg::CH_SEMI) begin
      sc_lex = scs_pkg::LX_COMMENT;
    end else if (b == scs_pkg::CH_RPAREN) begin
      if (sc_prefix != 0) return freeze(scs_pkg::LX_ERR_PREFIX, scs_pkg::ST_PREFIX_CLOSE);
      if (sc_depth == 0) return freeze(scs_pkg::LX_ERR_CLOSE, scs_pkg::ST_UNEXP_CLOSE);
      sc_depth = sc_depth - 16'd1;
    end else if (b == scs_pkg::CH_QUOTE || b == scs_pkg::CH_BQUOTE) begin
      bump_prefix();
    end else if (b == scs_pkg::CH_COMMA) begin
      bump_prefix();
      sc_lex = scs_pkg::LX_COMMA;
    end else if (b == scs_pkg::CH_HASH) begin
      sc_lex = scs_pkg::LX_HASH;
    end else if (b == scs_pkg::CH_LPAREN) begin
      return open_list();
    end else if (b == scs_pkg::CH_DQUOTE) begin
      sc_prefix = '0;
      sc_lex    = scs_pkg::LX_STRING;
    end else begin
      sc_prefix = '0;
      sc_lex    = scs_pkg::LX_ATOM;
    end
    step_position(b);
    return scs_pkg::ST_COMPLETE;
  endfunction

  function automatic scs_pkg::status_t scan_byte(logic [7:0] b);
    case (sc_lex)
      scs_pkg::LX_NORMAL: return top_level_byte(b);
      scs_pkg::LX_STRING: begin
        if (b == scs_pkg::CH_BSLASH) sc_lex = scs_pkg::LX_ESCAPE;
        else if (b == scs_pkg::CH_DQUOTE) sc_lex = scs_pkg::LX_NORMAL;
      end
      scs_pkg::LX_ESCAPE: sc_lex = scs_pkg::LX_STRING;
      scs_pkg::LX_COMMENT: begin
        if (b == scs_pkg::CH_NL) sc_lex = scs_pkg::LX_NORMAL;
      end
      scs_pkg::LX_HASH: begin
        if (b == scs_pkg::CH_QUOTE) begin
          bump_prefix();
          sc_lex = scs_pkg::LX_NORMAL;
        end else if (b == scs_pkg::CH_BSLASH) begin
          sc_prefix = '0;
          sc_lex    = scs_pkg::LX_CHAR;
        end else if (b == scs_pkg::CH_LPAREN) begin
          return open_list();
        end else begin
          sc_prefix = '0;
          if (is_delim(b)) return top_level_byte(b);
          sc_lex = scs_pkg::LX_ATOM;
        end
      end
      scs_pkg::LX_COMMA: begin
        if (b != scs_pkg::CH_AT) return top_level_byte(b);
        sc_lex = scs_pkg::LX_NORMAL;
      end
      scs_pkg::LX_CHAR: sc_lex = is_delim(b) ? scs_pkg::LX_NORMAL : scs_pkg::LX_ATOM;
      scs_pkg::LX_ATOM: begin
        if (is_delim(b)) return top_level_byte(b);
      end
      default: return scs_pkg::ST_COMPLETE;
    endcase
    step_position(b);
    return scs_pkg::ST_COMPLETE;
  endfunction

  // returns 1 when the beat owes a verdict, with the verdict in v
  function automatic bit scan_beat(logic mode, logic [7:0] b, output verdict_t v);
    scs_pkg::status_t s;
    v = '{scs_pkg::ST_COMPLETE, 24'd0, 16'd0};
    if (!mode) begin
      if (sc_lex inside {scs_pkg::LX_ERR_CLOSE, scs_pkg::LX_ERR_PREFIX,
                         scs_pkg::LX_ERR_DEPTH}) return 1'b0;
      s = scan_byte(b);
      if (s == scs_pkg::ST_COMPLETE) return 1'b0;
    end else begin
      case (sc_lex)
        scs_pkg::LX_ERR_CLOSE:  s = scs_pkg::ST_UNEXP_CLOSE;
        scs_pkg::LX_ERR_PREFIX: s = scs_pkg::ST_PREFIX_CLOSE;
        scs_pkg::LX_ERR_DEPTH:  s = scs_pkg::ST_NEST_OVF;
        default: begin
          // a lone hash at the end is an atom, so its prefixes do not count
          if (sc_lex inside {scs_pkg::LX_STRING, scs_pkg::LX_ESCAPE, scs_pkg::LX_CHAR} ||
              sc_depth != 0 || (sc_prefix != 0 && sc_lex != scs_pkg::LX_HASH))
            s = scs_pkg::ST_INCOMPLETE;
          else
            s = scs_pkg::ST_COMPLETE;
        end
      endcase
    end
    v.status = s;
    if (s inside {scs_pkg::ST_UNEXP_CLOSE, scs_pkg::ST_PREFIX_CLOSE,
                  scs_pkg::ST_NEST_OVF}) begin
      v.line   = sc_line;
      v.column = sc_col;
    end
    if (mode) begin
      // end of text starts the next one from scratch
      sc_lex    = scs_pkg::LX_NORMAL;
      sc_depth  = '0;
      sc_prefix = '0;
      sc_line   = 24'd1;
      sc_col    = 16'd1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // text driver: new beat on the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_mode       <= text_q[0].mode;
        in_byte_value <= text_q[0].byte_value;
        text_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the stall driver stays simple
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // verdict receiver stall
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted text beat, check every accepted verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_beats
    verdict_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && in_stall) n_backpressure++;
      if (in_valid && !in_stall) begin
        n_beats++;
        if (scan_beat(in_mode, in_byte_value, want)) verdict_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        n_by_status[out_status]++;
        if (verdict_q.size() == 0) begin
          $error("verdict with nothing owed: status %0d line %0d column %0d",
                 out_status, out_error_line, out_error_column);
          failed = 1'b1;
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            failed = 1'b1;
          end
          if (out_error_line !== want.line) begin
            $error("error_line: expected %0d, got %0d", want.line, out_error_line);
            failed = 1'b1;
          end
          if (out_error_column !== want.column) begin
            $error("error_column: expected %0d, got %0d", want.column, out_error_column);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b);
    text_beat_t t;
    t.mode       = 1'b0;
    t.byte_value = b;
    text_q.push_back(t);
    n_queued++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // end of text; the byte lane is don't-care here
  task automatic push_end(logic [7:0] b);
    text_beat_t t;
    t.mode       = 1'b1;
    t.byte_value = b;
    text_q.push_back(t);
    n_queued++;
  endtask

  // one random text built from lisp-like tokens, then the end marker
  task automatic gen_text();
    int ntok, depth, k;
    logic [7:0] b;
    ntok  = $urandom_range(0, 14);
    depth = 0;
    for (int t = 0; t < ntok; t++) begin
      k = $urandom_range(0, 99);
      if (k < 18) begin
        // list or vector open
        if ($urandom_range(0, 3) == 0) push_byte(scs_pkg::CH_HASH);
        push_byte(scs_pkg::CH_LPAREN);
        depth++;
      end else if (k < 34) begin
        // mostly balanced closes, now and then a stray one
        if (depth > 0 || $urandom_range(0, 4) == 0) begin
          push_byte(scs_pkg::CH_RPAREN);
          if (depth > 0) depth--;
        end
      end else if (k < 52) begin
        // atom of arbitrary non-delimiter bytes
        repeat ($urandom_range(1, 6)) begin
          do b = 8'($urandom_range(0, 255)); while (is_delim(b));
          push_byte(b);
        end
      end else if (k < 60) begin
        // string with escapes, sometimes left open
        push_byte(scs_pkg::CH_DQUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            push_byte(scs_pkg::CH_BSLASH);
            push_byte(8'($urandom_range(0, 255)));
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == scs_pkg::CH_DQUOTE || b == scs_pkg::CH_BSLASH) b = "s";
            push_byte(b);
          end
        end
        if ($urandom_range(0, 9) != 0) push_byte(scs_pkg::CH_DQUOTE);
      end else if (k < 66) begin
        // comment to end of line
        push_byte(scs_pkg::CH_SEMI);
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(0, 255));
          if (b == scs_pkg::CH_NL) b = "c";
          push_byte(b);
        end
        push_byte(scs_pkg::CH_NL);
      end else if (k < 78) begin
        // reader prefixes
        case ($urandom_range(0, 4))
          0: push_byte(scs_pkg::CH_QUOTE);
          1: push_byte(scs_pkg::CH_BQUOTE);
          2: push_byte(scs_pkg::CH_COMMA);
          3: begin
            push_byte(scs_pkg::CH_COMMA);
            push_byte(scs_pkg::CH_AT);
          end
          default: begin
            push_byte(scs_pkg::CH_HASH);
            push_byte(scs_pkg::CH_QUOTE);
          end
        endcase
      end else if (k < 84) begin
        // character literal
        push_byte(scs_pkg::CH_HASH);
        push_byte(scs_pkg::CH_BSLASH);
        push_byte(8'($urandom_range(0, 255)));
      end else if (k < 94) begin
        case ($urandom_range(0, 6))
          0: push_byte(scs_pkg::CH_SPACE);
          1: push_byte(scs_pkg::CH_TAB);
          2: push_byte(scs_pkg::CH_NL);
          3: push_byte(scs_pkg::CH_VT);
          4: push_byte(scs_pkg::CH_FF);
          5: push_byte(scs_pkg::CH_CR);
          default: push_byte(scs_pkg::CH_NUL);
        endcase
      end else begin
        // raw noise
        push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) < 6)
        push_byte($urandom_range(0, 3) == 0 ? scs_pkg::CH_NL : scs_pkg::CH_SPACE);
    end
    // most texts get closed, the rest end open
    if ($urandom_range(0, 9) < 8) repeat (depth) push_byte(scs_pkg::CH_RPAREN);
    push_end(8'($urandom_range(0, 255)));
  endtask

  // everything sent and every verdict back
  task automatic drain();
    while (text_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_texts
    int target;
    foreach (n_by_status[i]) n_by_status[i] = 0;

    // sender sparse-ish, receiver stalls often
    send_idle_pct = 34;
    recv_idle_pct = 60;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty text, with the ignored byte lane all ones
    push_end(8'hFF);
    // stray close, then a frozen byte, then the repeated error
    push_str(")x");
    push_end(8'h00);
    // close right after a quote
    push_str("')");
    push_end(8'h5A);
    // end inside a string escape
    push_str("\"a\\");
    push_end(8'h00);
    // end right after hash-backslash
    push_str("#\\");
    push_end(8'h00);
    // lone hash after a quote drops the prefix
    push_str("'#");
    push_end(8'h00);
    // vector holding the top byte and a zero delimiter
    push_str("#(");
    push_byte(8'hFF);
    push_byte(scs_pkg::CH_NUL);
    push_byte(scs_pkg::CH_RPAREN);
    push_end(8'h00);

    target = n_queued + RANDOM_BEATS;
    while (n_queued < target) gen_text();
    drain();

    // swap idling sides
    send_idle_pct = 60;
    recv_idle_pct = 34;
    target = n_queued + RANDOM_BEATS;
    while (n_queued < target) gen_text();
    drain();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long receiver hold-off while the sender streams end markers, each of
    // which owes a verdict, so the block backs up into its input
    hold_asked++;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) push_str("(a)");
      push_end(8'($urandom_range(0, 255)));
    end
    drain();

    // prefix count pinned at its top, still an error on the close
    repeat (PREFIX_RUN) push_byte(scs_pkg::CH_QUOTE);
    push_byte(scs_pkg::CH_RPAREN);
    push_end(8'h00);

    // a short run of random texts after the long one
    target = n_queued + 60;
    while (n_queued < target) gen_text();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("scanned %0d beats, checked %0d verdicts: %0d complete, %0d incomplete, %0d errors",
             n_beats, n_results, n_by_status[0], n_by_status[1],
             n_by_status[2] + n_by_status[3] + n_by_status[4]);
    $display("input held back on %0d cycles; prefix saturation and a long hold-off exercised",
             n_backpressure);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
